[rtl/core/emps_pkg.sv]
// shared types, constants and the font table of the emulator memory / pc / stack unit
// no dependencies
package emps_pkg;

	// sizes
	localparam int DEF_MEM_DEPTH = 4096;
	localparam int ADDR_W        = 12;
	localparam int BYTE_W        = 8;
	localparam int OPC_W         = 16;
	localparam int CMD_W         = 3;
	localparam int ST_W          = 3;
	localparam int LE_W          = 13;
	localparam int FONT_BYTES    = 80;
	localparam int FONT_IDX_W    = 7;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FETCH = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SKIP  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_JUMP  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CALL  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_RET   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd6;
	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd7;

	// status codes
	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_PC_RANGE  = 3'd1;
	localparam logic [ST_W-1:0] ST_STACK_OVF = 3'd2;
	localparam logic [ST_W-1:0] ST_STACK_UNF = 3'd3;
	localparam logic [ST_W-1:0] ST_LOAD_OVF  = 3'd4;

	// address map
	localparam logic [ADDR_W-1:0] PROG_START    = 12'h200;
	localparam logic [LE_W-1:0]   LOAD_START    = 13'h0200;
	localparam logic [ADDR_W-1:0] STACK_BASE    = 12'hEA0;
	localparam logic [ADDR_W-1:0] STACK_TOP     = 12'hEFF;
	localparam logic [ADDR_W-1:0] STACK_POP_MIN = 12'hEA2;
	localparam logic [ADDR_W-1:0] STACK_LIMIT   = 12'hF00;
	localparam logic [ADDR_W-1:0] LAST_ADDR     = 12'hFFF;

	// one port access of the byte memory
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] wdata;
	} ram_req_t;

	// hex digit sprites, five rows each
	localparam logic [BYTE_W-1:0] FONT_ROM [FONT_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

endpackage

[rtl/core/emps_ram.sv]
// generic single-port synchronous ram with registered read
// no dependencies
module emps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one access per cycle, read data registered and valid in the next cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[rtl/core/emps_clear.sv]
// post-reset sweep that loads the font sprites and zeroes the rest of memory
// depends on emps_pkg
module emps_clear
	import emps_pkg::*;
#(
	parameter int MEM_DEPTH = DEF_MEM_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	output logic     clearing,
	output ram_req_t req
);

	localparam int CW = $clog2(MEM_DEPTH) + 1;

	logic [CW-1:0] cnt_q;

	// sweep runs until the counter reaches the depth
	assign clearing = !cnt_q[CW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clearing) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// font bytes at the bottom, zero elsewhere
	always_comb begin
		req.we    = clearing;
		req.addr  = ADDR_W'(cnt_q[CW-2:0]);
		req.wdata = '0;
		if (cnt_q < CW'(FONT_BYTES)) begin
			req.wdata = FONT_ROM[cnt_q[FONT_IDX_W-1:0]];
		end
	end

	// sweep happens once per reset
	a_sweep_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clearing |=> !clearing)
		else $error("memory sweep restarted");

endmodule

[rtl/core/emps_ctrl.sv]
// command sequencer: pc, stack pointer, load pointer, sticky error, memory accesses
// depends on emps_pkg
module emps_ctrl
	import emps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [ADDR_W-1:0] address,
	input  logic [BYTE_W-1:0] data,
	input  logic [BYTE_W-1:0] ram_rdata,
	output ram_req_t          ram_req,
	output logic              busy,
	output logic              done,
	output logic [OPC_W-1:0]  opcode,
	output logic [BYTE_W-1:0] read_data,
	output logic [ADDR_W-1:0] pc,
	output logic [ST_W-1:0]   status
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SECOND = 2'd1;
	localparam logic [1:0] S_LAST   = 2'd2;

	logic [1:0]        state_q, state_d;
	logic [CMD_W-1:0]  cmd_q, cmd_d;
	logic [ADDR_W-1:0] addr_q, addr_d;
	logic [BYTE_W-1:0] byte_q, byte_d;
	logic [ADDR_W-1:0] pc_q, pc_d;
	logic [ADDR_W-1:0] sp_q, sp_d;
	logic [LE_W-1:0]   le_q, le_d;
	logic [ST_W-1:0]   err_q, err_d;
	logic              finish;
	logic [OPC_W-1:0]  opc_d;
	logic [BYTE_W-1:0] rd_d;
	logic [LE_W-1:0]   skip_next;
	logic              done_q;
	logic [OPC_W-1:0]  opcode_q;
	logic [BYTE_W-1:0] read_data_q;
	logic [ADDR_W-1:0] pc_out_q;
	logic [ST_W-1:0]   status_q;

	assign skip_next = {1'b0, pc_q} + LE_W'(2);
	assign busy      = (state_q != S_IDLE);

	// next state and memory access for each step of a request
	always_comb begin
		state_d = state_q;
		cmd_d   = cmd_q;
		addr_d  = addr_q;
		byte_d  = byte_q;
		pc_d    = pc_q;
		sp_d    = sp_q;
		le_d    = le_q;
		err_d   = err_q;
		finish  = 1'b0;
		opc_d   = '0;
		rd_d    = '0;
		ram_req = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_d  = cmd;
					addr_d = address;
					if (err_q != ST_OK) begin
						finish = 1'b1;
					end else begin
						case (cmd)
							CMD_LOAD: begin
								finish = 1'b1;
								if (le_q[LE_W-1]) begin
									err_d = ST_LOAD_OVF;
								end else begin
									ram_req.we    = 1'b1;
									ram_req.addr  = le_q[ADDR_W-1:0];
									ram_req.wdata = data;
									le_d          = le_q + LE_W'(1);
								end
							end
							CMD_FETCH: begin
								if (({1'b0, pc_q} == le_q) || (pc_q == LAST_ADDR)) begin
									err_d  = ST_PC_RANGE;
									finish = 1'b1;
								end else begin
									ram_req.addr = pc_q;
									state_d      = S_SECOND;
								end
							end
							CMD_SKIP: begin
								finish = 1'b1;
								if (skip_next[LE_W-1] || (skip_next == le_q)) begin
									err_d = ST_PC_RANGE;
								end else begin
									pc_d = skip_next[ADDR_W-1:0];
								end
							end
							CMD_JUMP: begin
								pc_d   = address;
								finish = 1'b1;
							end
							CMD_CALL: begin
								if (sp_q >= STACK_TOP) begin
									err_d  = ST_STACK_OVF;
									finish = 1'b1;
								end else begin
									// high byte of the return address first
									ram_req.we    = 1'b1;
									ram_req.addr  = sp_q;
									ram_req.wdata = BYTE_W'(pc_q[ADDR_W-1:BYTE_W]);
									state_d       = S_SECOND;
								end
							end
							CMD_RET: begin
								if (sp_q < STACK_POP_MIN) begin
									err_d  = ST_STACK_UNF;
									finish = 1'b1;
								end else begin
									ram_req.addr = sp_q - ADDR_W'(1);
									state_d      = S_SECOND;
								end
							end
							CMD_READ: begin
								ram_req.addr = address;
								state_d      = S_LAST;
							end
							CMD_WRITE: begin
								ram_req.we    = 1'b1;
								ram_req.addr  = address;
								ram_req.wdata = data;
								finish        = 1'b1;
							end
							default: begin
								finish = 1'b1;
							end
						endcase
					end
				end
			end
			S_SECOND: begin
				case (cmd_q)
					CMD_FETCH: begin
						ram_req.addr = pc_q + ADDR_W'(1);
						byte_d       = ram_rdata;
						state_d      = S_LAST;
					end
					CMD_RET: begin
						ram_req.addr = sp_q - ADDR_W'(2);
						byte_d       = ram_rdata;
						state_d      = S_LAST;
					end
					CMD_CALL: begin
						ram_req.we    = 1'b1;
						ram_req.addr  = sp_q + ADDR_W'(1);
						ram_req.wdata = pc_q[BYTE_W-1:0];
						sp_d          = sp_q + ADDR_W'(2);
						pc_d          = addr_q;
						finish        = 1'b1;
						state_d       = S_IDLE;
					end
					default: begin
						finish  = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end
			S_LAST: begin
				case (cmd_q)
					CMD_FETCH: begin
						opc_d = {byte_q, ram_rdata};
						pc_d  = pc_q + ADDR_W'(2);
					end
					CMD_RET: begin
						// popped word cut to twelve bits
						pc_d = {ram_rdata[ADDR_W-BYTE_W-1:0], byte_q};
						sp_d = sp_q - ADDR_W'(2);
					end
					CMD_READ: begin
						rd_d = ram_rdata;
					end
					default: begin
					end
				endcase
				finish  = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= PROG_START;
			sp_q    <= STACK_BASE;
			le_q    <= LOAD_START;
			err_q   <= ST_OK;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
			sp_q    <= sp_d;
			le_q    <= le_d;
			err_q   <= err_d;
			done_q  <= finish;
		end
	end

	// request context and result registers
	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		addr_q <= addr_d;
		byte_q <= byte_d;
		if (finish) begin
			opcode_q    <= opc_d;
			read_data_q <= rd_d;
			pc_out_q    <= pc_d;
			status_q    <= err_d;
		end
	end

	assign done      = done_q;
	assign opcode    = opcode_q;
	assign read_data = read_data_q;
	assign pc        = pc_out_q;
	assign status    = status_q;

	// multi-cycle requests only start when no error is pending
	a_busy_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (err_q == ST_OK))
		else $error("multi-cycle request running with error set");

	// error code never changes once set
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK) |=> (err_q == $past(err_q)))
		else $error("sticky error changed");

	// stack pointer stays even and inside the stack area
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		!sp_q[0] && (sp_q >= STACK_BASE) && (sp_q <= STACK_LIMIT))
		else $error("stack pointer out of range");

	// last step only collects read data
	a_last_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LAST) |-> !ram_req.we)
		else $error("memory write in final step");

endmodule

[rtl/core/emulator_memory_pc_stack_unit.sv]
// Emulated 4 KiB machine memory with program counter and in-memory return stack.
// After reset the block sweeps its single-port byte RAM, one byte per cycle, writing
// the font sprites into bytes 0 to 79 and zero elsewhere: busy stays high while the
// sweep runs and no request is taken during it. A request is taken when start is
// high and busy is low. Every request gives exactly one result, shown for one cycle
// with done high the cycle after the request's last step; the receiver cannot stall
// it. Each memory byte takes one RAM port access, so fetch and return use the idle,
// second and last steps (two reads plus the registered read latency), read the idle
// and last, call the idle and second, and load, skip, jump, write and any request
// that errors or meets a pending error only the idle step, so they may start each cycle.
// depends on emps_pkg, emps_ram, emps_clear, emps_ctrl
module emulator_memory_pc_stack_unit
	import emps_pkg::*;
#(
	parameter int MEM_DEPTH = DEF_MEM_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [ADDR_W-1:0] address,
	input  logic [BYTE_W-1:0] data,
	output logic              done,
	output logic [OPC_W-1:0]  opcode,
	output logic [BYTE_W-1:0] read_data,
	output logic [ADDR_W-1:0] pc,
	output logic [ST_W-1:0]   status
);

	localparam int AW = $clog2(MEM_DEPTH);

	logic              clearing;
	logic              ctrl_busy;
	logic              accept;
	ram_req_t          clr_req;
	ram_req_t          ctrl_req;
	ram_req_t          ram_req;
	logic [BYTE_W-1:0] ram_rdata;

	// request handshake
	assign busy   = clearing | ctrl_busy;
	assign accept = start & ~busy;

	// reset sweep owns the ram port until it finishes
	assign ram_req = clearing ? clr_req : ctrl_req;

	emps_clear #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_clear (
		.clk     (clk),
		.arst_n  (arst_n),
		.clearing(clearing),
		.req     (clr_req)
	);

	emps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.address  (address),
		.data     (data),
		.ram_rdata(ram_rdata),
		.ram_req  (ctrl_req),
		.busy     (ctrl_busy),
		.done     (done),
		.opcode   (opcode),
		.read_data(read_data),
		.pc       (pc),
		.status   (status)
	);

	emps_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MEM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_req.we),
		.addr (ram_req.addr[AW-1:0]),
		.wdata(ram_req.wdata),
		.rdata(ram_rdata)
	);

endmodule
